FILE: sv/mbd_pkg.sv
// Shared types, register indexes and the bytewise halving add for the 2x2 box downsampler.
package mbd_pkg;

    localparam int CHAN_W     = 8;
    localparam int NUM_CHAN   = 4;
    localparam int WIDTH_W    = 12;
    localparam int HEIGHT_W   = 15;
    localparam int ROW_W      = 14;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    localparam logic [HEIGHT_W-1:0] HEIGHT_LIMIT = 15'd16384;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 12'd2048;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 15'd2048;
    localparam logic                FOUR_RESET   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FOUR_CHANNELS = 2'd2;

    typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] pix_t;

    // Position flags of one request, handed from the position logic to the filter stage.
    typedef struct packed {
        logic hold;
        logic emit;
        logic row_end;
        logic frame_end;
    } mbd_tag_t;

    function automatic pix_t half_add(input pix_t p, input pix_t q);
        pix_t                r;
        logic [CHAN_W:0]     s;
        r = '0;
        for (int k = 0; k < NUM_CHAN; k++)
        begin
            s    = {1'b0, p[k]} + {1'b0, q[k]};
            r[k] = s[CHAN_W:1];
        end
        return r;
    endfunction

endpackage

FILE: sv/mbd_line_store.sv
// Single-port line store of even-row pixels with registered read data.
module mbd_line_store #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic             rd_en,
    input  logic [AW-1:0]    addr,
    input  mbd_pkg::pix_t    wdata,
    output mbd_pkg::pix_t    rdata
);
    import mbd_pkg::*;

    pix_t mem [DEPTH];
    pix_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/mbd_ctrl.sv
// Configuration registers and the source pixel position counters.
module mbd_ctrl #(
    parameter int MAX_WIDTH = 2048,
    parameter int XW        = 11
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic [mbd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mbd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_fire,
    output logic [XW-1:0]                    col,
    output logic                             odd_row,
    output mbd_pkg::mbd_tag_t                tag,
    output logic                             four_channels,
    output logic                             restart
);
    import mbd_pkg::*;

    localparam int MW = $clog2(MAX_WIDTH + 1);
    localparam int EW = (MW > WIDTH_W) ? MW : WIDTH_W;
    localparam logic [EW-1:0] MAX_W = EW'(MAX_WIDTH);

    logic [WIDTH_W-1:0]  width_reg,  width_next;
    logic [HEIGHT_W-1:0] height_reg, height_next;
    logic                four_reg,   four_next;
    logic [XW-1:0]       col_reg,    col_next;
    logic [ROW_W-1:0]    row_reg,    row_next;

    logic [EW-1:0]       eff_w, out_cols, col_ext;
    logic [HEIGHT_W-1:0] eff_h, out_rows, row_ext;

    always_comb
    begin
        restart     = 1'b0;
        width_next  = width_reg;
        height_next = height_reg;
        four_next   = four_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:
                begin
                    width_next = cfg_data[WIDTH_W-1:0];
                    restart    = 1'b1;
                end
                REG_IMAGE_HEIGHT:
                begin
                    height_next = cfg_data[HEIGHT_W-1:0];
                    restart     = 1'b1;
                end
                REG_FOUR_CHANNELS:
                begin
                    four_next = cfg_data[0];
                    restart   = 1'b1;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    // Saturate the programmed size and treat zero as one.
    always_comb
    begin
        eff_w = EW'(width_reg);
        if (eff_w > MAX_W)
        begin
            eff_w = MAX_W;
        end
        if (eff_w == '0)
        begin
            eff_w = EW'(1);
        end
        eff_h = height_reg;
        if (eff_h > HEIGHT_LIMIT)
        begin
            eff_h = HEIGHT_LIMIT;
        end
        if (eff_h == '0)
        begin
            eff_h = HEIGHT_W'(1);
        end
    end

    assign out_cols = {eff_w[EW-1:1], 1'b0};
    assign out_rows = {eff_h[HEIGHT_W-1:1], 1'b0};
    assign col_ext  = EW'(col_reg);
    assign row_ext  = HEIGHT_W'(row_reg);

    always_comb
    begin
        tag.hold      = row_reg[0] && (col_ext < out_cols) && !col_reg[0];
        tag.emit      = row_reg[0] && (col_ext < out_cols) && col_reg[0]
                        && (row_ext < out_rows);
        tag.row_end   = (col_ext == out_cols - EW'(1));
        tag.frame_end = tag.row_end && (row_ext == out_rows - HEIGHT_W'(1));
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (in_fire)
        begin
            if (col_ext + EW'(1) >= eff_w)
            begin
                col_next = '0;
                if (row_ext + HEIGHT_W'(1) >= eff_h)
                begin
                    row_next = '0;
                end
                else
                begin
                    row_next = row_reg + ROW_W'(1);
                end
            end
            else
            begin
                col_next = col_reg + XW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            four_reg   <= FOUR_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            four_reg   <= four_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

    assign col           = col_reg;
    assign odd_row       = row_reg[0];
    assign four_channels = four_reg;

endmodule

FILE: sv/mbd_filter.sv
// Vertical and horizontal halving adds, held even-column average and the output register.
module mbd_filter (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_fire,
    input  mbd_pkg::mbd_tag_t         tag,
    input  mbd_pkg::pix_t             pix,
    input  mbd_pkg::pix_t             above,
    input  logic                      four_channels,
    input  logic                      clear_held,
    input  logic                      out_ready,
    output logic                      in_ready,
    output logic                      out_valid,
    output mbd_pkg::pix_t             out_pix,
    output logic                      row_end,
    output logic                      frame_end
);
    import mbd_pkg::*;

    logic     s1_valid_reg, s1_valid_next;
    mbd_tag_t s1_tag_reg;
    pix_t     s1_pix_reg;
    pix_t     held_reg;
    logic     out_valid_reg, out_valid_next;
    pix_t     out_pix_reg;
    logic     row_end_reg, frame_end_reg;

    logic     s1_adv;
    pix_t     vert, result;

    // The stage stalls only when it carries an output and the output register is stuck.
    assign s1_adv   = s1_valid_reg && (!s1_tag_reg.emit || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;

    assign vert   = half_add(above, s1_pix_reg);
    assign result = half_add(held_reg, vert);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (s1_adv && s1_tag_reg.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            held_reg      <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (clear_held)
            begin
                held_reg <= '0;
            end
            else if (s1_adv && s1_tag_reg.hold)
            begin
                held_reg <= vert;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_tag_reg <= tag;
            s1_pix_reg <= pix;
        end
        if (s1_adv && s1_tag_reg.emit)
        begin
            out_pix_reg[2:0] <= result[2:0];
            out_pix_reg[3]   <= four_channels ? result[3] : '0;
            row_end_reg      <= s1_tag_reg.row_end;
            frame_end_reg    <= s1_tag_reg.frame_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pix   = out_pix_reg;
    assign row_end   = row_end_reg;
    assign frame_end = frame_end_reg;

endmodule

FILE: sv/mipmap_box_downsample_2x2.sv
// Top level of the 2x2 box-filter mipmap downsampler.
// Usage: source pixels enter in row order on in_valid/in_ready, one request per
// pixel with channels chan_a..chan_d. Downsampled pixels leave on
// out_valid/out_ready with out_a..out_d, row_end and frame_end. One output
// pixel follows each odd-column pixel of an odd source row; trailing odd
// columns and rows give nothing. Registers must be set over cfg_valid/cfg_index/
// cfg_data (always ready) by the user only while the block is idle; the block
// does not enforce this. A write to a defined register restarts the frame.
// Throughput: one pixel per clock unless the output stalls. Each pixel reads or
// writes the line store once through its single port: even rows write, odd rows
// read the pixel above. The pixel and its line store read are registered ahead of
// the output register. When the receiver stalls, pixels keep being taken until
// one that completes an output sits in the filter stage; in_ready then follows
// out_ready. Reset clears the counters, the held average and all valid flags, and
// sets width 2048, height 2048 and four-channel mode. The line store is not
// cleared: every frame writes an entry on an even row before an odd row reads it.
module mipmap_box_downsample_2x2 #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       chan_a,
    input  logic [7:0]                       chan_b,
    input  logic [7:0]                       chan_c,
    input  logic [7:0]                       chan_d,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [7:0]                       out_a,
    output logic [7:0]                       out_b,
    output logic [7:0]                       out_c,
    output logic [7:0]                       out_d,
    output logic                             row_end,
    output logic                             frame_end,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mbd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mbd_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import mbd_pkg::*;

    localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic          in_fire;
    logic [XW-1:0] col;
    logic          odd_row;
    mbd_tag_t      tag;
    logic          four_channels;
    logic          restart;
    pix_t          pix, above, out_pix;

    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && in_ready;
    assign pix       = {chan_d, chan_c, chan_b, chan_a};

    mbd_ctrl #(
        .MAX_WIDTH (MAX_WIDTH),
        .XW        (XW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_fire       (in_fire),
        .col           (col),
        .odd_row       (odd_row),
        .tag           (tag),
        .four_channels (four_channels),
        .restart       (restart)
    );

    mbd_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (XW)
    ) u_store (
        .clk   (clk),
        .wr_en (in_fire && !odd_row),
        .rd_en (in_fire && odd_row),
        .addr  (col),
        .wdata (pix),
        .rdata (above)
    );

    mbd_filter u_filter (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_fire       (in_fire),
        .tag           (tag),
        .pix           (pix),
        .above         (above),
        .four_channels (four_channels),
        .clear_held    (restart),
        .out_ready     (out_ready),
        .in_ready      (in_ready),
        .out_valid     (out_valid),
        .out_pix       (out_pix),
        .row_end       (row_end),
        .frame_end     (frame_end)
    );

    assign out_a = out_pix[0];
    assign out_b = out_pix[1];
    assign out_c = out_pix[2];
    assign out_d = out_pix[3];

endmodule

FILE: sv/mbd_checker.sv
// Port-level checks of the downsampler and their binding to the top level.
module mbd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_a,
    input logic [7:0] out_d,
    input logic       row_end,
    input logic       frame_end
);

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_a) && $stable(out_d))
        else $error("stalled result changed");

    a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> row_end)
        else $error("frame end without row end");

    // Only a full, stalled output path may drop in_ready.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output backpressure");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without a request two cycles earlier");

endmodule

bind mipmap_box_downsample_2x2 mbd_checker u_mbd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_a     (out_a),
    .out_d     (out_d),
    .row_end   (row_end),
    .frame_end (frame_end)
);

FILE: tb/mbd_scoreboard_pkg.sv
// Scoreboard class: predicts the downsampled pixels and checks them as they leave the block.
package mbd_scoreboard_pkg;
    import mbd_pkg::*;

    localparam int unsigned LINE_DEPTH    = 2048;
    localparam int unsigned TALL_LIMIT    = 16384;
    localparam int          REPORT_LIMIT  = 200;

    // Channel k of a pixel sits in byte k: a, b, c, d.
    typedef logic [3:0][7:0] quad_t;

    typedef struct packed {
        quad_t chan;
        logic  row_end;
        logic  frame_end;
    } down_pixel_t;

    class box_downsample_scoreboard;
        logic [WIDTH_W-1:0]  width_reg;
        logic [HEIGHT_W-1:0] height_reg;
        logic                four_reg;
        quad_t               line_buf [LINE_DEPTH];
        int unsigned         col;
        int unsigned         row;
        quad_t               held_avg;
        down_pixel_t         expected_q [$];
        int                  errors;

        function new();
            width_reg  = 12'd2048;
            height_reg = 15'd2048;
            four_reg   = 1'b1;
            errors     = 0;
            restart_frame();
        endfunction

        function void restart_frame();
            col      = 0;
            row      = 0;
            held_avg = '0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function quad_t halve_sum(quad_t p, quad_t q);
            quad_t      r;
            logic [8:0] s;
            for (int k = 0; k < 4; k++)
            begin
                s    = p[k] + q[k];
                r[k] = s[8:1];
            end
            return r;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_IMAGE_WIDTH:   width_reg  = data[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT:  height_reg = data[HEIGHT_W-1:0];
                REG_FOUR_CHANNELS: four_reg   = data[0];
                default:           return;
            endcase
            restart_frame();
        endfunction

        function void note_pixel(quad_t pix);
            int unsigned w;
            int unsigned h;
            int unsigned x;
            int unsigned y;
            int unsigned out_cols;
            int unsigned out_rows;
            quad_t       v;
            down_pixel_t res;
            w = width_reg;
            if (w > LINE_DEPTH)
                w = LINE_DEPTH;
            if (w == 0)
                w = 1;
            h = height_reg;
            if (h > TALL_LIMIT)
                h = TALL_LIMIT;
            if (h == 0)
                h = 1;
            x = (col >= w) ? w - 1 : col;
            y = (row >= h) ? h - 1 : row;
            if ((y % 2) == 0)
                line_buf[x] = pix;
            else
            begin
                out_cols = (w / 2) * 2;
                out_rows = (h / 2) * 2;
                v = halve_sum(line_buf[x], pix);
                if (x < out_cols)
                begin
                    if ((x % 2) == 0)
                        held_avg = v;
                    else if (y < out_rows)
                    begin
                        res.chan = halve_sum(held_avg, v);
                        if (!four_reg)
                            res.chan[3] = '0;
                        res.row_end   = (x == out_cols - 1);
                        res.frame_end = res.row_end && (y == out_rows - 1);
                        expected_q.push_back(res);
                    end
                end
            end
            x++;
            if (x >= w)
            begin
                x = 0;
                y++;
                if (y >= h)
                    y = 0;
            end
            col = x;
            row = y;
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            end
        endfunction

        function void check_pixel(down_pixel_t got);
            down_pixel_t want;
            string       names [4];
            names = '{"out_a", "out_b", "out_c", "out_d"};
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: output pixel expected none got %h", $time, got);
                return;
            end
            want = expected_q.pop_front();
            for (int k = 0; k < 4; k++)
                compare_field(names[k], want.chan[k], got.chan[k]);
            compare_field("row_end", want.row_end, got.row_end);
            compare_field("frame_end", want.frame_end, got.frame_end);
        endfunction
    endclass

endpackage

FILE: tb/tb_top.sv
// Testbench top: streams images and register writes into the 2x2 downsampler and checks its output.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mbd_pkg::*;
    import mbd_scoreboard_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS  = 1250;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 300;
    localparam int DRAIN_LIMIT   = 5000;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic [7:0]            chan_a    = '0;
    logic [7:0]            chan_b    = '0;
    logic [7:0]            chan_c    = '0;
    logic [7:0]            chan_d    = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [7:0]            out_a;
    logic [7:0]            out_b;
    logic [7:0]            out_c;
    logic [7:0]            out_d;
    logic                  row_end;
    logic                  frame_end;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    box_downsample_scoreboard sb;

    int send_gap_max = 4;
    int recv_gap_max = 4;
    bit hold_off_req = 1'b0;

    mipmap_box_downsample_2x2 dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .chan_a    (chan_a),
        .chan_b    (chan_b),
        .chan_c    (chan_c),
        .chan_d    (chan_d),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_a     (out_a),
        .out_b     (out_b),
        .out_c     (out_c),
        .out_d     (out_d),
        .row_end   (row_end),
        .frame_end (frame_end),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #4_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_pixel('{chan: {out_d, out_c, out_b, out_a},
                             row_end: row_end, frame_end: frame_end});
    end

    // Receiver: random stall before each request, and one long hold-off on demand.
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            stall = $urandom_range(0, recv_gap_max);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    function automatic quad_t rand_pixel();
        quad_t p;
        for (int k = 0; k < 4; k++)
        begin
            case ($urandom_range(0, 7))
                0:       p[k] = 8'h00;
                1:       p[k] = 8'hff;
                default: p[k] = 8'($urandom);
            endcase
        end
        return p;
    endfunction

    // Called and returns just after a falling edge; valid stays high across back-to-back requests.
    task automatic send_pixel(input quad_t pix);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        {chan_d, chan_c, chan_b, chan_a} <= pix;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_pixel(pix);
        @(negedge clk);
    endtask

    task automatic send_random(input int unsigned count);
        repeat (count)
            send_pixel(rand_pixel());
    endtask

    // Drop valid, wait for every expected pixel, then let the pipeline empty.
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Leaves cfg_valid high; the caller drops it after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_register(idx, data);
        @(negedge clk);
    endtask

    task automatic configure(input int unsigned w, input int unsigned h, input bit four);
        settle();
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_UNUSED, 15'($urandom));
        // upper data bits above the register width must be ignored
        write_reg(REG_IMAGE_WIDTH, {3'($urandom), 12'(w)});
        write_reg(REG_IMAGE_HEIGHT, 15'(h));
        write_reg(REG_FOUR_CHANNELS, {14'($urandom), four});
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int unsigned w;
        int unsigned h;
        int unsigned count;
        int          random_items;
        int          phase;
        bit          four;
        sb = new();
        random_items = 0;
        phase = 0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: start of a 2048x2048 RGBA frame
        send_pixel(32'h00000000);
        send_pixel(32'hffffffff);

        // 2x4 RGBA with extreme bytes; an unused index mid-frame must not restart it
        configure(2, 4, 1'b1);
        send_pixel(32'hff00ff00);
        send_pixel(32'h01ff0080);
        send_pixel(32'hff01ff01);
        send_pixel(32'hffffffff);
        settle();
        write_reg(REG_UNUSED, 15'h7fff);
        cfg_valid <= 1'b0;
        send_pixel(32'h00000000);
        send_pixel(32'h00000000);
        send_pixel(32'h7f807f80);
        send_pixel(32'h01010101);

        // 3x3 RGB: drop the trailing column and row, then wrap into the next frame
        configure(3, 3, 1'b0);
        repeat (11)
            send_pixel(rand_pixel());

        // degenerate sizes give no output
        configure(1, 2, 1'b1);
        send_random(2);
        configure(0, 0, 1'b1);
        send_random(2);

        while (random_items < RANDOM_ITEMS)
        begin
            send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 4;
            recv_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 4;
            four = $urandom_range(0, 1);
            phase++;
            if (phase == 2)
            begin
                // long receiver hold-off while the sender keeps pushing
                send_gap_max = 0;
                configure(16, 8, four);
                hold_off_req = 1'b1;
                send_random(16 * 8);
                random_items += 16 * 8;
            end
            else if (phase == 4)
            begin
                // pause the sender mid-frame until all pixels are out
                configure(6, 6, four);
                send_random(6 * 3 + 2);
                settle();
                send_random(6 * 3 - 2);
                random_items += 6 * 6;
            end
            else if (phase == 6)
            begin
                // width beyond the line store saturates to its depth; send the
                // first row and the start of the second
                send_gap_max = 0;
                configure(4095, 2, four);
                count = LINE_DEPTH + 64;
                send_random(count);
                random_items += count;
            end
            else
            begin
                case ($urandom_range(0, 11))
                    0:
                    begin
                        if ($urandom_range(0, 1) == 1)
                        begin
                            w = $urandom_range(0, 1);
                            h = $urandom_range(0, 9);
                        end
                        else
                        begin
                            w = $urandom_range(0, 4095);
                            h = $urandom_range(0, 1);
                        end
                        configure(w, h, four);
                        count = $urandom_range(4, 24);
                        send_random(count);
                        random_items += count;
                    end
                    1:
                    begin
                        // height beyond the limit saturates; only the top rows are sent
                        w = $urandom_range(2, 6);
                        h = $urandom_range(16385, 32767);
                        configure(w, h, four);
                        count = w * $urandom_range(4, 16);
                        send_random(count);
                        random_items += count;
                    end
                    default:
                    begin
                        w = $urandom_range(2, 12);
                        h = $urandom_range(2, 8);
                        configure(w, h, four);
                        count = w * h * $urandom_range(1, 3);
                        // sometimes stop partway into a frame
                        if ($urandom_range(0, 3) == 0)
                            count += $urandom_range(1, w * h - 1);
                        send_random(count);
                        random_items += count;
                    end
                endcase
            end
        end

        in_valid <= 1'b0;
        for (int i = 0; i < DRAIN_LIMIT && sb.pending() != 0; i++)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (sb.pending() != 0)
        begin
            sb.errors++;
            $display("%0t: %0d output pixels expected got none", $time, sb.pending());
        end
        if (sb.errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
